// ===== src/spc_pkg.sv =====
// ---------------------------------------------------------------------------
// spc_pkg: shared types and constants of the sphere pair collision block
// Object record, compare stage status, controller states and sizes.
// ---------------------------------------------------------------------------
package spc_pkg;

  // Frame capacity (2..32) and the widths that follow from it
  localparam int MAX_OBJECTS = 32;
  localparam int IDX_W       = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int CNT_W       = $clog2(MAX_OBJECTS + 1);
  // Width of the index fields on the result ports
  localparam int OUT_IDX_W   = 5;

  // One stored object
  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic        [14:0] radius;
    logic        [15:0] defend;
    logic        [15:0] attack;
  } obj_t;

  // Status of the pair test stage seen by the controller
  typedef struct packed {
    logic             valid;   // stage holds a compare
    logic             hit;     // spheres overlap and a mask pairing is set
    logic             first;   // stored defend & new attack non-zero
    logic             second;  // stored attack & new defend non-zero
    logic [IDX_W-1:0] idx;     // arrival index of the stored object
  } test_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } state_t;

endpackage

// ===== src/spc_cell.sv =====
// ---------------------------------------------------------------------------
// spc_cell: one cell of the object ring
// Holds one stored object; takes its neighbor's object on a shift, or the
// new object on a load.
// ---------------------------------------------------------------------------
module spc_cell import spc_pkg::*; (
  input  logic clk,
  input  logic shift,
  input  logic load,
  input  obj_t shift_in,
  input  obj_t load_in,
  output obj_t q
);

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      q <= load_in;
    end else if (shift) begin
      q <= shift_in;
    end
  end

endmodule

// ===== src/spc_pair_test.sv =====
// ---------------------------------------------------------------------------
// spc_pair_test: sphere overlap and mask test for one stored object
// Registers the squared axis distances, squared radius sum and mask flags,
// then sums and compares behind that register.
// ---------------------------------------------------------------------------
module spc_pair_test import spc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,     // take a new beat (else hold)
  input  logic             load_valid,  // the beat carries a real compare
  input  obj_t             stored,
  input  obj_t             probe,
  input  logic [IDX_W-1:0] idx,
  output test_t            status
);

  logic             valid;
  logic [31:0]      dx2;
  logic [31:0]      dy2;
  logic [31:0]      dz2;
  logic [31:0]      rsq;
  logic             first;
  logic             second;
  logic [IDX_W-1:0] idx_q;

  logic [15:0] ax;
  logic [15:0] ay;
  logic [15:0] az;
  logic [15:0] rsum;
  logic [33:0] dist2;

  // absolute difference of two signed coordinates, fits in 16 bits
  function automatic logic [15:0] abs_diff(input logic signed [15:0] a,
                                           input logic signed [15:0] b);
    logic signed [16:0] d;
    logic signed [16:0] m;
    d = {a[15], a} - {b[15], b};
    m = d[16] ? -d : d;
    return m[15:0];
  endfunction

  assign ax   = abs_diff(stored.pos_x, probe.pos_x);
  assign ay   = abs_diff(stored.pos_y, probe.pos_y);
  assign az   = abs_diff(stored.pos_z, probe.pos_z);
  assign rsum = {1'b0, stored.radius} + {1'b0, probe.radius};

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= load_valid;
    end
  end

  // squares and flags
  always_ff @(posedge clk) begin
    if (advance) begin
      dx2    <= ax * ax;
      dy2    <= ay * ay;
      dz2    <= az * az;
      rsq    <= rsum * rsum;
      first  <= |(stored.defend & probe.attack);
      second <= |(stored.attack & probe.defend);
      idx_q  <= idx;
    end
  end

  // sum of squares against squared radius sum
  assign dist2 = {2'b00, dx2} + {2'b00, dy2} + {2'b00, dz2};

  assign status.valid  = valid;
  assign status.hit    = valid && (first || second) && (dist2 < {2'b00, rsq});
  assign status.first  = first;
  assign status.second = second;
  assign status.idx    = idx_q;

endmodule

// ===== src/sphere_pair_collision_with_masks.sv =====
// ---------------------------------------------------------------------------
// sphere_pair_collision_with_masks: mask-filtered sphere overlap pair finder
//
// Input: one object per beat, taken at a clock edge with start high and
// busy low. first_of_frame empties the store before the object is handled.
// The object is tested against every stored object of the frame, oldest
// first, then stored at the next arrival index. When the store is full the
// object is dropped and busy stays low.
// Results: one beat per cycle on hitter_index/target_index/last_hit, marked
// by result_valid for exactly one cycle; last_hit marks the final result of
// an object. The receiver cannot hold results off.
// Timing: stored objects sit in a ring of MAX_OBJECTS cells that turns one
// cell per cycle, unless a two-result hit stalls it, past a single pair test
// unit; an accepted object keeps busy high until the ring has turned round,
// held longer by each stored object that both hits and is hit by the new one
// (two results). The last result appears in the same cycle that busy falls.
// Reset: empties the frame; stored contents stay as they were.
// ---------------------------------------------------------------------------
module sphere_pair_collision_with_masks import spc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 first_of_frame,
  input  logic signed [15:0]   pos_x,
  input  logic signed [15:0]   pos_y,
  input  logic signed [15:0]   pos_z,
  input  logic        [14:0]   radius,
  input  logic        [15:0]   defend_mask,
  input  logic        [15:0]   attack_mask,
  output logic                 result_valid,
  output logic [OUT_IDX_W-1:0] hitter_index,
  output logic [OUT_IDX_W-1:0] target_index,
  output logic                 last_hit
);

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] k_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  obj_t             probe;
  obj_t             probe_next;
  logic             half;
  logic             half_next;
  logic             hold_valid;
  logic             hold_valid_next;
  logic [IDX_W-1:0] hold_hitter;
  logic [IDX_W-1:0] hold_hitter_next;
  logic [IDX_W-1:0] hold_target;
  logic [IDX_W-1:0] hold_target_next;
  logic                 result_valid_next;
  logic [OUT_IDX_W-1:0] hitter_index_next;
  logic [OUT_IDX_W-1:0] target_index_next;
  logic                 last_hit_next;

  obj_t             ring [MAX_OBJECTS];
  obj_t             new_obj;
  test_t            tst;
  logic             stall;
  logic             ring_shift;
  logic             ring_load;
  logic             load_valid;
  logic [CNT_W-1:0] eff_n;
  logic [IDX_W-1:0] n_idx;
  logic [IDX_W-1:0] res_hitter;
  logic [IDX_W-1:0] res_target;

  assign new_obj = '{pos_x: pos_x, pos_y: pos_y, pos_z: pos_z, radius: radius,
                     defend: defend_mask, attack: attack_mask};
  assign n_idx   = count[IDX_W-1:0];

  // object ring: cell 0 faces the pair test, each cell takes from the next
  for (genvar i = 0; i < MAX_OBJECTS; i++) begin : g_ring
    spc_cell u_cell (
      .clk      (clk),
      .shift    (ring_shift),
      .load     (ring_load && (n_idx == IDX_W'(i))),
      .shift_in (ring[(i + 1) % MAX_OBJECTS]),
      .load_in  (probe),
      .q        (ring[i])
    );
  end

  spc_pair_test u_test (
    .clk        (clk),
    .rst        (rst),
    .advance    (!stall),
    .load_valid (load_valid),
    .stored     (ring[0]),
    .probe      (probe),
    .idx        (k),
    .status     (tst)
  );

  // a two-result hit holds the stage for its second result
  assign stall = tst.hit && tst.first && tst.second && !half;

  // result of this cycle's hit: stored-hits-new goes first
  always_comb begin
    if (half || !tst.first) begin
      res_hitter = n_idx;
      res_target = tst.idx;
    end else begin
      res_hitter = tst.idx;
      res_target = n_idx;
    end
  end

  assign busy = (state != ST_IDLE);

  // state and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      half         <= 1'b0;
      hold_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      half         <= half_next;
      hold_valid   <= hold_valid_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    k            <= k_next;
    probe        <= probe_next;
    hold_hitter  <= hold_hitter_next;
    hold_target  <= hold_target_next;
    hitter_index <= hitter_index_next;
    target_index <= target_index_next;
    last_hit     <= last_hit_next;
  end

  // next state, result sequencing
  always_comb begin
    state_next        = state;
    k_next            = k;
    count_next        = count;
    probe_next        = probe;
    half_next         = stall;
    hold_valid_next   = hold_valid;
    hold_hitter_next  = hold_hitter;
    hold_target_next  = hold_target;
    result_valid_next = 1'b0;
    hitter_index_next = hitter_index;
    target_index_next = target_index;
    last_hit_next     = last_hit;
    ring_shift        = 1'b0;
    ring_load         = 1'b0;
    load_valid        = 1'b0;
    eff_n             = first_of_frame ? '0 : count;

    // a new result pushes the held one out; the last one waits for the end
    if (tst.hit) begin
      if (hold_valid) begin
        result_valid_next = 1'b1;
        hitter_index_next = OUT_IDX_W'(hold_hitter);
        target_index_next = OUT_IDX_W'(hold_target);
        last_hit_next     = 1'b0;
      end
      hold_valid_next  = 1'b1;
      hold_hitter_next = res_hitter;
      hold_target_next = res_target;
    end

    case (state)
      ST_IDLE: begin
        if (start) begin
          count_next = eff_n;
          if (eff_n < CNT_W'(MAX_OBJECTS)) begin
            probe_next = new_obj;
            k_next     = '0;
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (!stall) begin
          ring_shift = 1'b1;
          load_valid = (CNT_W'(k) < count);
          k_next     = k + 1'b1;
          if (k == IDX_W'(MAX_OBJECTS - 1)) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!tst.valid) begin
          // ring is back in order: store the new object, close the item
          ring_load  = 1'b1;
          count_next = count + CNT_W'(1);
          if (hold_valid) begin
            result_valid_next = 1'b1;
            hitter_index_next = OUT_IDX_W'(hold_hitter);
            target_index_next = OUT_IDX_W'(hold_target);
            last_hit_next     = 1'b1;
          end
          hold_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
